// ===== design/rrts_pkg.sv =====
// Package for the round-robin task scheduler with signals.
// Holds the command/status structs, operation codes and fixed sizes.
// No dependencies; used by rrts_ctrl, rrts_dpath and the top level.
package rrts_pkg;

	localparam int TASK_COUNT   = 16;
	localparam int SIGNAL_COUNT = 32;
	localparam int TASK_W       = 4;
	localparam int SIG_W        = 5;
	localparam int HADDR_W      = TASK_W + SIG_W;
	localparam int HDEPTH       = TASK_COUNT * SIGNAL_COUNT;

	localparam logic [2:0] FN_CREATE = 3'd0;
	localparam logic [2:0] FN_TICK   = 3'd1;
	localparam logic [2:0] FN_KILL   = 3'd2;
	localparam logic [2:0] FN_SETH   = 3'd3;
	localparam logic [2:0] FN_EXIT   = 3'd4;

	localparam logic [SIG_W-1:0] SIG_KILL = 5'd9;
	localparam logic [SIG_W-1:0] SIG_SEGV = 5'd11;
	localparam logic [SIG_W-1:0] SIG_TERM = 5'd15;

	localparam logic [15:0] FLOOR_RESET    = 16'h1000;
	localparam logic [63:0] FRAME_BYTES    = 64'd56;
	localparam logic [63:0] HANDLER_IGNORE = 64'd1;
	localparam logic [63:0] HANDLER_DFL    = 64'd0;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic create;
		logic kill;
		logic err;
		logic exit_mark;
		logic scan_load;
		logic scan_rd;
		logic eval;
		logic push;
		logic pop;
		logic sh_rd;
		logic sh_wr;
		logic res_load;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic       clr_done;
		logic [2:0] func;
		logic       cur_exited;
		logic       cur_idle;
		logic       sig_bad;
		logic       mask_zero;
		logic       eval_more;
		logic       pop_done;
		logic       out_free;
	} sts_t;

endpackage

// ===== design/rrts_ctrl.sv =====
// Sequencing state machine of the task scheduler.
// Depends on rrts_pkg; drives rrts_dpath through cmd_t and reads sts_t.
module rrts_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  rrts_pkg::sts_t sts,
	output rrts_pkg::cmd_t cmd
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_EVAL   = 4'd3;
	localparam logic [3:0] S_PUSH   = 4'd4;
	localparam logic [3:0] S_POP    = 4'd5;
	localparam logic [3:0] S_SHWR   = 4'd6;
	localparam logic [3:0] S_DONE   = 4'd7;

	logic [3:0] state_q, state_d;

	assign in_ready = (state_q == S_IDLE) && sts.clr_done;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid && in_ready) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				unique case (sts.func)
					rrts_pkg::FN_CREATE: begin
						cmd.create = 1'b1;
						state_d    = S_DONE;
					end
					rrts_pkg::FN_TICK: begin
						if (sts.cur_exited) begin
							state_d = S_POP;
						end else begin
							cmd.scan_load = 1'b1;
							state_d       = S_SCAN;
						end
					end
					rrts_pkg::FN_KILL: begin
						cmd.kill = 1'b1;
						state_d  = S_DONE;
					end
					rrts_pkg::FN_SETH: begin
						if (sts.sig_bad) begin
							cmd.err = 1'b1;
							state_d = S_DONE;
						end else begin
							cmd.sh_rd = 1'b1;
							state_d   = S_SHWR;
						end
					end
					rrts_pkg::FN_EXIT: begin
						if (sts.cur_idle) begin
							cmd.err = 1'b1;
							state_d = S_DONE;
						end else begin
							cmd.exit_mark = 1'b1;
							state_d       = S_POP;
						end
					end
					default: begin
						cmd.err = 1'b1;
						state_d = S_DONE;
					end
				endcase
			end
			S_SCAN: begin
				if (sts.mask_zero) begin
					state_d = S_PUSH;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				state_d  = sts.eval_more ? S_SCAN : S_PUSH;
			end
			S_PUSH: begin
				cmd.push = 1'b1;
				state_d  = S_POP;
			end
			S_POP: begin
				cmd.pop = 1'b1;
				if (sts.pop_done) state_d = S_DONE;
			end
			S_SHWR: begin
				cmd.sh_wr = 1'b1;
				state_d   = S_DONE;
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

endmodule

// ===== design/rrts_dpath.sv =====
// Datapath of the task scheduler: task state, ready queue, handler memory,
// operand and result registers. Depends on rrts_pkg; driven by rrts_ctrl.
module rrts_dpath (
	input  logic           clk,
	input  logic           arst_n,
	input  rrts_pkg::cmd_t cmd,
	output rrts_pkg::sts_t sts,
	input  logic [2:0]     in_func,
	input  logic [175:0]   in_data,
	input  logic           cfg_we,
	input  logic [15:0]    cfg_wdata,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [207:0]   out_data
);

	localparam int TC = rrts_pkg::TASK_COUNT;
	localparam int TW = rrts_pkg::TASK_W;
	localparam int SW = rrts_pkg::SIG_W;
	localparam int SC = rrts_pkg::SIGNAL_COUNT;
	localparam int AW = rrts_pkg::HADDR_W;

	// Operands of the current item.
	logic [2:0]    func_q;
	logic [TW-1:0] target_q;
	logic [SW-1:0] sig_q;
	logic [63:0]   handler_q, usp_q;

	// Scheduler state.
	logic [15:0]   floor_q;
	logic [TW-1:0] running_q;
	logic [TW:0]   created_q;
	logic          exited_q [TC];
	logic [SC-1:0] pend_q   [TC];
	logic [TW-1:0] fifo_q   [TC];
	logic [TW-1:0] head_q;
	logic [TW:0]   count_q;

	// Signal scan.
	logic [SC-1:0] mask_q;
	logic [SW-1:0] scan_sig_q;

	// Handler memory and its clearing pass.
	logic [63:0]   hmem [rrts_pkg::HDEPTH];
	logic [63:0]   rdata_q;
	logic [AW:0]   clr_q;

	// Result registers.
	logic          r_status_q, r_sw_q, r_del_q, out_valid_q;
	logic [TW-1:0] r_id_q;
	logic [63:0]   r_dh_q, r_fsp_q, r_old_q;
	logic [SW-1:0] r_dsig_q;
	logic [207:0]  out_data_q;

	logic          clearing;
	logic [SW-1:0] low_idx;
	logic [TW-1:0] tail, head_id;
	logic [63:0]   frame_sp;
	logic          below_floor, default_kill, kill_bad, q_full;
	logic          mem_we, mem_re;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [63:0]   mem_wd;

	assign clearing = !clr_q[AW];
	assign tail     = head_q + count_q[TW-1:0];
	assign head_id  = fifo_q[head_q];
	assign q_full   = (count_q >= (TW+1)'(TC));
	assign frame_sp = usp_q - rrts_pkg::FRAME_BYTES;
	assign below_floor = (usp_q < rrts_pkg::FRAME_BYTES) || (frame_sp < {48'b0, floor_q});
	assign default_kill = (scan_sig_q == rrts_pkg::SIG_KILL) ||
		(scan_sig_q == rrts_pkg::SIG_SEGV) || (scan_sig_q == rrts_pkg::SIG_TERM);
	assign kill_bad = ({1'b0, sig_q} >= (SW+1)'(SC)) || ({1'b0, target_q} >= created_q) ||
		exited_q[target_q];

	always_comb begin
		low_idx = '0;
		for (int i = SC - 1; i >= 1; i--) begin
			if (mask_q[i]) low_idx = SW'(i);
		end
	end

	always_comb begin
		sts.clr_done   = !clearing;
		sts.func       = func_q;
		sts.cur_exited = exited_q[running_q];
		sts.cur_idle   = (running_q == '0);
		sts.sig_bad    = ({1'b0, sig_q} >= (SW+1)'(SC)) || (sig_q == rrts_pkg::SIG_KILL);
		sts.mask_zero  = (mask_q == '0);
		sts.eval_more  = (rdata_q == rrts_pkg::HANDLER_IGNORE) ||
			((rdata_q == rrts_pkg::HANDLER_DFL) && !default_kill);
		sts.pop_done   = (count_q == '0) || !exited_q[head_id];
		sts.out_free   = !out_valid_q || out_ready;
	end

	// Handler memory: the clearing pass owns the write port until it ends.
	assign mem_we = clearing || cmd.sh_wr;
	assign mem_wa = clearing ? clr_q[AW-1:0] : {running_q, sig_q};
	assign mem_wd = clearing ? 64'd0 : handler_q;
	assign mem_re = cmd.scan_rd || cmd.sh_rd;
	assign mem_ra = cmd.scan_rd ? {running_q, low_idx} : {running_q, sig_q};

	always_ff @(posedge clk) begin
		if (mem_we) hmem[mem_wa] <= mem_wd;
		if (mem_re) rdata_q <= hmem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (clearing) clr_q <= clr_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) floor_q <= rrts_pkg::FLOOR_RESET;
		else if (cfg_we) floor_q <= cfg_wdata;
	end

	// Operands and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			func_q    <= in_func;
			target_q  <= in_data[3:0];
			sig_q     <= in_data[8:4];
			handler_q <= in_data[72:9];
			usp_q     <= in_data[136:73];
		end
		if (cmd.scan_rd) scan_sig_q <= low_idx;
	end

	// Scheduler state and results.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= '0;
			created_q <= (TW+1)'(1);
			head_q    <= '0;
			count_q   <= '0;
			mask_q    <= '0;
			for (int i = 0; i < TC; i++) begin
				exited_q[i] <= 1'b0;
				pend_q[i]   <= '0;
				fifo_q[i]   <= '0;
			end
			r_status_q <= 1'b0;
			r_sw_q     <= 1'b0;
			r_del_q    <= 1'b0;
			r_id_q     <= '0;
			r_dh_q     <= '0;
			r_fsp_q    <= '0;
			r_dsig_q   <= '0;
			r_old_q    <= '0;
		end else begin
			if (cmd.latch) begin
				r_status_q <= 1'b0;
				r_sw_q     <= 1'b0;
				r_del_q    <= 1'b0;
				r_id_q     <= running_q;
				r_dh_q     <= '0;
				r_fsp_q    <= '0;
				r_dsig_q   <= '0;
				r_old_q    <= '0;
			end
			if (cmd.err) r_status_q <= 1'b1;
			if (cmd.create) begin
				if (created_q >= (TW+1)'(TC)) begin
					r_status_q <= 1'b1;
				end else begin
					created_q <= created_q + 1'b1;
					exited_q[created_q[TW-1:0]] <= 1'b0;
					pend_q[created_q[TW-1:0]]   <= '0;
					r_id_q <= created_q[TW-1:0];
					if (!q_full) begin
						fifo_q[tail] <= created_q[TW-1:0];
						count_q      <= count_q + 1'b1;
					end
				end
			end
			if (cmd.kill) begin
				if (kill_bad) r_status_q <= 1'b1;
				else if (sig_q == rrts_pkg::SIG_KILL) exited_q[target_q] <= 1'b1;
				else pend_q[target_q] <= pend_q[target_q] | (SC'(1) << sig_q);
			end
			if (cmd.exit_mark) exited_q[running_q] <= 1'b1;
			if (cmd.scan_load) mask_q <= pend_q[running_q] & ~SC'(1);
			if (cmd.eval) begin
				// Handled or cleared signals drop out of both the scan copy and the task.
				mask_q[scan_sig_q] <= 1'b0;
				if (rdata_q == rrts_pkg::HANDLER_IGNORE) begin
					pend_q[running_q][scan_sig_q] <= 1'b0;
				end else if (rdata_q == rrts_pkg::HANDLER_DFL) begin
					if (default_kill) exited_q[running_q] <= 1'b1;
					else pend_q[running_q][scan_sig_q] <= 1'b0;
				end else if (below_floor) begin
					exited_q[running_q] <= 1'b1;
				end else begin
					pend_q[running_q][scan_sig_q] <= 1'b0;
					r_del_q  <= 1'b1;
					r_dh_q   <= rdata_q;
					r_fsp_q  <= frame_sp;
					r_dsig_q <= scan_sig_q;
				end
			end
			if (cmd.push && (running_q != '0) && !exited_q[running_q] && !q_full) begin
				fifo_q[tail] <= running_q;
				count_q      <= count_q + 1'b1;
			end
			if (cmd.pop) begin
				if (count_q == '0) begin
					running_q <= '0;
					r_id_q    <= '0;
					r_sw_q    <= (running_q != '0);
				end else begin
					head_q  <= head_q + 1'b1;
					count_q <= count_q - 1'b1;
					if (!exited_q[head_id]) begin
						running_q <= head_id;
						r_id_q    <= head_id;
						r_sw_q    <= (head_id != running_q);
					end
				end
			end
			if (cmd.sh_wr) r_old_q <= rdata_q;
		end
	end

	// Output register: holds the result steady while the next item is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
			out_data_q  <= {4'b0, r_old_q, r_dsig_q, r_fsp_q, r_dh_q, r_del_q, r_sw_q,
				r_id_q, r_status_q};
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (TW+1)'(TC)) else $error("ready queue count beyond depth");
	a_created_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(created_q >= (TW+1)'(1)) && (created_q <= (TW+1)'(TC)))
		else $error("task id allocator out of range");
	a_res_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.res_load |-> (!out_valid_q || out_ready))
		else $error("result loaded over a waiting result");
	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !cmd.latch) else $error("item accepted during clearing pass");

endmodule

// ===== design/round_robin_task_scheduler_signals.sv =====
// Top level of the round-robin task scheduler with per-task signals.
// Depends on rrts_pkg, rrts_ctrl and rrts_dpath.
//
//   Channel  Direction  Handshake           Payload
//   s_*      in         s_tvalid/s_tready   s_tuser = func, s_tdata = operands
//   m_*      out        m_tvalid/m_tready   m_tdata = result
//   cfg_*    in         cfg_we              cfg_wdata = stack_floor
//
// Every item passes DECODE and ends in DONE. Create, kill, set handler with a bad
// signal, exit on idle and unused codes go straight from DECODE to DONE. Set
// handler also passes SHWR, since it reads the old handler from the handler
// memory. Tick scans the pending signals in SCAN and EVAL (one handler memory
// read and one evaluation each), stopping at a signal that is delivered or kills
// the task, then pushes the task in PUSH and drops exited tasks from the ready
// queue head in POP; a tick on an already exited task and exit current go
// straight to POP. One item is processed at a time.
// After reset a clearing pass zeroes the 512-entry handler memory, one entry
// per cycle, and s_tready stays low until it ends; configuration writes are
// taken throughout. The result sits in an output register, so the next item
// is accepted while m_tvalid waits on m_tready; that item then holds in its final
// state, DONE, until the waiting result has transferred.
module round_robin_task_scheduler_signals (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// s_tuser: func[2:0]
	input  logic [2:0]   s_tuser,
	// s_tdata: target_task[3:0], signal_num[8:4], handler[72:9],
	//          user_stack_ptr[136:73], exit_value[168:137], zero fill
	input  logic [175:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// m_tdata: status[0], task_id[4:1], switched[5], deliver[6],
	//          deliver_handler[70:7], frame_stack_ptr[134:71],
	//          deliver_signal[139:135], prev_handler[203:140], zero fill
	output logic [207:0] m_tdata,
	input  logic         cfg_we,
	input  logic [15:0]  cfg_wdata
);

	rrts_pkg::cmd_t cmd;
	rrts_pkg::sts_t sts;

	// The controller only sequences; all task state lives in the datapath.
	rrts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rrts_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_func   (s_tuser),
		.in_data   (s_tdata),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (m_tdata)
	);

endmodule
